FILE: sv/gbn_pkg.sv
package gbn_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned SeqPortW = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned SeqExtW  = 8;
  localparam int unsigned DataMaxW = 32;

  localparam logic [CmdW-1:0] CMD_PACKET   = 2'd0;
  localparam logic [CmdW-1:0] CMD_FRAME    = 2'd1;
  localparam logic [CmdW-1:0] CMD_CKSUM    = 2'd2;
  localparam logic [CmdW-1:0] CMD_TIMEOUT  = 2'd3;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_RECV,
    OP_NOP,
    OP_REPLAY
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_REPLAY,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic                valid;
    op_e                 op;
    logic [SeqPortW-1:0] rx_seq;
    logic [SeqPortW-1:0] rx_ack;
  } head_t;

  // a <= b < c, circularly
  function automatic logic in_window(logic [SeqExtW-1:0] a, logic [SeqExtW-1:0] b,
                                     logic [SeqExtW-1:0] c);
    in_window = ((a <= b) && (b < c)) || ((c < a) && (b < c)) || ((c < a) && (a <= b));
  endfunction

endpackage

FILE: sv/go_back_n_sliding_window.sv
// Channel   Handshake        Payload
// -------   --------------   ---------------------------------------------------------
// event     push / full      cmd_i, payload_in_i, rx_seq_i, rx_ack_i
// result    empty / pop      kind_o, tx_seq_o, tx_ack_o, payload_out_o,
//                            stopped_timers_o, network_enable_o, last_o
//
// Events wait in a two-entry queue; the sequencer takes one event at a time.
// Packet ready or checksum error: a frame if one is sent, then status.
// Frame arrival: n frames acked, one per cycle by the ack walker, then status.
// Timeout: outstanding frames resent from the packet buffer, one per cycle while the result slot is free.
// Async active-low reset empties the queue and the window; the buffer is not cleared.
// A result held by a low pop stalls the sequencer only; events still queue up.
module go_back_n_sliding_window #(
  parameter int unsigned MAX_SEQUENCE = 7,
  parameter int unsigned PACKET_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [gbn_pkg::CmdW-1:0]      cmd_i,
  input  logic [PACKET_WIDTH-1:0]       payload_in_i,
  input  logic [gbn_pkg::SeqPortW-1:0]  rx_seq_i,
  input  logic [gbn_pkg::SeqPortW-1:0]  rx_ack_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [gbn_pkg::SeqPortW-1:0]  tx_seq_o,
  output logic [gbn_pkg::SeqPortW-1:0]  tx_ack_o,
  output logic [PACKET_WIDTH-1:0]       payload_out_o,
  output logic [gbn_pkg::MaskW-1:0]     stopped_timers_o,
  output logic                          network_enable_o,
  output logic                          last_o
);
  import gbn_pkg::*;

  head_t                   head;
  logic [PACKET_WIDTH-1:0] head_payload;
  logic                    take;
  kind_e                   kind;

  gbn_front #(
    .PacketW (PACKET_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .cmd_i          (cmd_i),
    .payload_i      (payload_in_i),
    .rx_seq_i       (rx_seq_i),
    .rx_ack_i       (rx_ack_i),
    .head_o         (head),
    .head_payload_o (head_payload),
    .take_i         (take)
  );

  gbn_back #(
    .MaxSeq  (MAX_SEQUENCE),
    .PacketW (PACKET_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_payload_i   (head_payload),
    .take_o           (take),
    .empty_o          (empty),
    .pop_i            (pop),
    .kind_o           (kind),
    .tx_seq_o         (tx_seq_o),
    .tx_ack_o         (tx_ack_o),
    .payload_o        (payload_out_o),
    .stopped_o        (stopped_timers_o),
    .network_enable_o (network_enable_o),
    .last_o           (last_o)
  );

  assign kind_o = kind;

endmodule

FILE: sv/gbn_front.sv
module gbn_front #(
  parameter int unsigned PacketW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [gbn_pkg::CmdW-1:0]      cmd_i,
  input  logic [PacketW-1:0]            payload_i,
  input  logic [gbn_pkg::SeqPortW-1:0]  rx_seq_i,
  input  logic [gbn_pkg::SeqPortW-1:0]  rx_ack_i,
  output gbn_pkg::head_t                head_o,
  output logic [PacketW-1:0]            head_payload_o,
  input  logic                          take_i
);
  import gbn_pkg::*;

  localparam int unsigned Depth = 2;

  op_e                 op_q      [Depth];
  logic [PacketW-1:0]  payload_q [Depth];
  logic [SeqPortW-1:0] seq_q     [Depth];
  logic [SeqPortW-1:0] ack_q     [Depth];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                wr_en, rd_en;
  op_e                 op_class;

  always_comb begin
    unique case (cmd_i)
      CMD_PACKET:  op_class = OP_SEND;
      CMD_FRAME:   op_class = OP_RECV;
      CMD_CKSUM:   op_class = OP_NOP;
      CMD_TIMEOUT: op_class = OP_REPLAY;
      default:     op_class = OP_NOP;
    endcase
  end

  assign full_o = (count_q == 2'(Depth));
  assign wr_en  = push_i && !full_o;
  assign rd_en  = take_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      op_q[wr_ptr_q]      <= op_class;
      payload_q[wr_ptr_q] <= payload_i;
      seq_q[wr_ptr_q]     <= rx_seq_i;
      ack_q[wr_ptr_q]     <= rx_ack_i;
    end
  end

  always_comb begin
    head_o.valid   = (count_q != 2'd0);
    head_o.op      = op_q[rd_ptr_q];
    head_o.rx_seq  = seq_q[rd_ptr_q];
    head_o.rx_ack  = ack_q[rd_ptr_q];
    head_payload_o = payload_q[rd_ptr_q];
  end

endmodule

FILE: sv/gbn_back.sv
module gbn_back #(
  parameter int unsigned MaxSeq  = 7,
  parameter int unsigned PacketW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbn_pkg::head_t                head_i,
  input  logic [PacketW-1:0]            head_payload_i,
  output logic                          take_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output gbn_pkg::kind_e                kind_o,
  output logic [gbn_pkg::SeqPortW-1:0]  tx_seq_o,
  output logic [gbn_pkg::SeqPortW-1:0]  tx_ack_o,
  output logic [PacketW-1:0]            payload_o,
  output logic [gbn_pkg::MaskW-1:0]     stopped_o,
  output logic                          network_enable_o,
  output logic                          last_o
);
  import gbn_pkg::*;

  localparam int unsigned SeqW  = (MaxSeq < 2) ? 1 : $clog2(MaxSeq + 1);
  localparam int unsigned Depth = MaxSeq + 1;
  localparam int unsigned DataW = (PacketW < DataMaxW) ? PacketW : DataMaxW;
  localparam logic [SeqW-1:0] MaxSeqV = SeqW'(MaxSeq);

  function automatic logic [SeqW-1:0] seq_inc(logic [SeqW-1:0] s);
    seq_inc = (s == MaxSeqV) ? '0 : s + 1'b1;
  endfunction

  state_e              state_q, state_d;
  logic [SeqW-1:0]     nts_q, nts_d;
  logic [SeqW-1:0]     oldest_q, oldest_d;
  logic [SeqW-1:0]     expected_q, expected_d;
  logic [SeqW-1:0]     outstanding_q, outstanding_d;
  logic [SeqW-1:0]     cnt_q, cnt_d;
  logic [SeqPortW-1:0] rack_q, rack_d;
  logic [MaskW-1:0]    stopped_q, stopped_d;
  logic [DataW-1:0]    store [Depth];
  logic [DataW-1:0]    rd_data_q;
  logic [SeqW-1:0]     rd_addr;
  logic                store_we;

  logic                out_valid_q;
  kind_e               kind_q;
  logic [SeqPortW-1:0] tx_seq_q, tx_ack_q;
  logic [DataW-1:0]    payload_q;
  logic [MaskW-1:0]    stopped_out_q;
  logic                ne_q, last_q;

  logic                emit;
  kind_e               e_kind;
  logic [SeqW-1:0]     e_seq;
  logic [DataW-1:0]    e_payload;
  logic                slot_free, win_full, deliver, slide, take;
  logic [SeqW-1:0]     ack_val;
  logic [SeqExtW-1:0]  oldest_ext;
  logic [MaskW-1:0]    oldest_bit;

  assign slot_free = !out_valid_q || pop_i;
  assign win_full  = (outstanding_q >= MaxSeqV);
  assign deliver   = (SeqExtW'(head_i.rx_seq) == SeqExtW'(expected_q));
  assign slide     = (outstanding_q != '0) &&
                     in_window(SeqExtW'(oldest_q), SeqExtW'(rack_q), SeqExtW'(nts_q));
  assign ack_val   = (expected_q == '0) ? MaxSeqV : expected_q - 1'b1;
  assign oldest_ext = SeqExtW'(oldest_q);
  assign oldest_bit = (oldest_ext < SeqExtW'(MaskW)) ? (MaskW'(1) << oldest_ext[2:0]) : '0;

  always_comb begin
    take = 1'b0;
    if (state_q == ST_IDLE && head_i.valid) begin
      unique case (head_i.op)
        OP_SEND:   take = win_full || slot_free;
        OP_RECV:   take = !deliver || slot_free;
        OP_NOP:    take = 1'b1;
        OP_REPLAY: take = 1'b1;
        default:   take = 1'b0;
      endcase
    end
  end

  assign take_o = take;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (head_i.op)
            OP_RECV:   state_d = ST_ACK;
            OP_REPLAY: state_d = (outstanding_q == '0) ? ST_STATUS : ST_REPLAY;
            default:   state_d = ST_STATUS;
          endcase
        end
      end
      ST_ACK:    state_d = slide ? ST_ACK : ST_STATUS;
      ST_REPLAY: begin
        if (slot_free && (cnt_q == outstanding_q - 1'b1)) begin
          state_d = ST_STATUS;
        end
      end
      ST_STATUS: state_d = slot_free ? ST_IDLE : ST_STATUS;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    nts_d         = nts_q;
    oldest_d      = oldest_q;
    expected_d    = expected_q;
    outstanding_d = outstanding_q;
    cnt_d         = cnt_q;
    rack_d        = rack_q;
    stopped_d     = stopped_q;
    rd_addr       = nts_q;
    store_we      = 1'b0;
    emit          = 1'b0;
    e_kind        = KIND_STATUS;
    e_seq         = '0;
    e_payload     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (head_i.op)
            OP_SEND: begin
              if (!win_full) begin
                store_we      = 1'b1;
                emit          = 1'b1;
                e_kind        = KIND_DATA;
                e_seq         = nts_q;
                e_payload     = DataW'(head_payload_i);
                nts_d         = seq_inc(nts_q);
                outstanding_d = outstanding_q + 1'b1;
              end
            end
            OP_RECV: begin
              rack_d = head_i.rx_ack;
              if (deliver) begin
                emit       = 1'b1;
                e_kind     = KIND_DELIVER;
                e_payload  = DataW'(head_payload_i);
                expected_d = seq_inc(expected_q);
              end
            end
            OP_REPLAY: begin
              nts_d   = oldest_q;
              cnt_d   = '0;
              rd_addr = oldest_q;
            end
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (slide) begin
          stopped_d     = stopped_q | oldest_bit;
          oldest_d      = seq_inc(oldest_q);
          outstanding_d = outstanding_q - 1'b1;
        end
      end
      ST_REPLAY: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_kind    = KIND_DATA;
          e_seq     = nts_q;
          e_payload = rd_data_q;
          nts_d     = seq_inc(nts_q);
          cnt_d     = cnt_q + 1'b1;
          rd_addr   = seq_inc(nts_q);
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_kind    = KIND_STATUS;
          stopped_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      nts_q         <= '0;
      oldest_q      <= '0;
      expected_q    <= '0;
      outstanding_q <= '0;
      cnt_q         <= '0;
      rack_q        <= '0;
      stopped_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      nts_q         <= nts_d;
      oldest_q      <= oldest_d;
      expected_q    <= expected_d;
      outstanding_q <= outstanding_d;
      cnt_q         <= cnt_d;
      rack_q        <= rack_d;
      stopped_q     <= stopped_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q        <= e_kind;
      payload_q     <= e_payload;
      tx_seq_q      <= (e_kind == KIND_DATA) ? SeqPortW'(SeqExtW'(e_seq)) : '0;
      tx_ack_q      <= (e_kind == KIND_DATA) ? SeqPortW'(SeqExtW'(ack_val)) : '0;
      stopped_out_q <= (e_kind == KIND_STATUS) ? stopped_q : '0;
      ne_q          <= (e_kind == KIND_STATUS) && (outstanding_q < MaxSeqV);
      last_q        <= (e_kind == KIND_STATUS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store[nts_q] <= DataW'(head_payload_i);
    end
    rd_data_q <= store[rd_addr];
  end

  assign empty_o          = !out_valid_q;
  assign kind_o           = kind_q;
  assign tx_seq_o         = tx_seq_q;
  assign tx_ack_o         = tx_ack_q;
  assign payload_o        = PacketW'(payload_q);
  assign stopped_o        = stopped_out_q;
  assign network_enable_o = ne_q;
  assign last_o           = last_q;

endmodule

FILE: sv/gbn_checker.sv
module gbn_checker #(
  parameter int unsigned PACKET_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          empty,
  input logic                          pop,
  input logic [1:0]                    kind_o,
  input logic [gbn_pkg::SeqPortW-1:0]  tx_seq_o,
  input logic [gbn_pkg::SeqPortW-1:0]  tx_ack_o,
  input logic [PACKET_WIDTH-1:0]       payload_out_o,
  input logic [gbn_pkg::MaskW-1:0]     stopped_timers_o,
  input logic                          network_enable_o,
  input logic                          last_o
);
  import gbn_pkg::*;

  // status ends every event, and only status does
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (kind_o == KIND_STATUS)))
    else $error("last flag does not match status kind");

  a_flags_on_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_STATUS) |-> (stopped_timers_o == '0 && !network_enable_o))
    else $error("status flags set on a frame result");

  a_no_seq_off_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_DATA) |-> (tx_seq_o == '0 && tx_ack_o == '0))
    else $error("sequence fields set on a non-data result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(payload_out_o) && $stable(kind_o)))
    else $error("waiting result changed before pop");

endmodule

bind go_back_n_sliding_window gbn_checker #(
  .PACKET_WIDTH (PACKET_WIDTH)
) u_gbn_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .kind_o           (kind_o),
  .tx_seq_o         (tx_seq_o),
  .tx_ack_o         (tx_ack_o),
  .payload_out_o    (payload_out_o),
  .stopped_timers_o (stopped_timers_o),
  .network_enable_o (network_enable_o),
  .last_o           (last_o)
);
